// File: sv/polyline_arc_length_interpolator_macros.svh
// Assertion macros for the polyline arc-length interpolator.
// Used by the top level; the enclosing module must provide clk and rst.
`ifndef POLYLINE_ARC_LENGTH_INTERPOLATOR_MACROS_SVH
`define POLYLINE_ARC_LENGTH_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define PLAL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside of reset.
`define PLAL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/plal_pkg.sv
// Package for the polyline arc-length interpolator.
// Holds command and status codes, fraction constants and the sequencer state type; no dependencies.
`default_nettype none

package plal_pkg;

  localparam logic       CMD_LOAD  = 1'b0;
  localparam logic       CMD_QUERY = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_LOAD = 2'd1;
  localparam logic [1:0] STATUS_FEW  = 2'd2;

  localparam int         FRAC_BITS = 16;
  localparam logic [16:0] FRAC_ONE = 17'd65536;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PT_RD,
    S_L_RD,
    S_SQ,
    S_ACC,
    S_SQRT,
    S_TMUL_GO,
    S_TMUL,
    S_SCAN,
    S_SEL,
    S_A_RD,
    S_B_RD,
    S_IMUL_GO,
    S_IMUL,
    S_IDIV,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// File: sv/plal_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the vertex store and the segment length table; no dependencies.
`default_nettype none

module plal_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 72
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/plal_sqrt.sv
// Iterative integer square root, one root bit per cycle (restoring method).
// Standalone unit; no dependencies.
`default_nettype none

module plal_sqrt #(
  parameter int ROOT_W = 33
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [2*ROOT_W-1:0]   radicand,
  output logic                       done,
  output logic      [ROOT_W-1:0]     root
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] x;
  logic [ROOT_W+1:0]   rem;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic [ROOT_W+1:0]   rem_sh;
  logic [ROOT_W+1:0]   trial;

  assign rem_sh = {rem[ROOT_W-1:0], x[2*ROOT_W-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= CNT_W'(ROOT_W);
        x    <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        x <= {x[2*ROOT_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/plal_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
// Standalone unit; no dependencies.
`default_nettype none

module plal_mul #(
  parameter int AW = 49,
  parameter int BW = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [AW-1:0]      a,
  input  wire logic [BW-1:0]      b,
  output logic                    done,
  output logic      [AW+BW-1:0]   prod
);

  localparam int CNT_W = $clog2(BW + 1);

  logic [AW+BW-1:0] ash;
  logic [BW-1:0]    bsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= CNT_W'(BW);
        ash  <= (AW+BW)'(a);
        bsh  <= b;
        prod <= '0;
      end else if (busy) begin
        if (bsh[0]) begin
          prod <= prod + ash;
        end
        ash  <= {ash[AW+BW-2:0], 1'b0};
        bsh  <= {1'b0, bsh[BW-1:1]};
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/plal_div.sv
// Restoring divider, one quotient bit per cycle; quotient must fit QW bits.
// Standalone unit; no dependencies.
`default_nettype none

module plal_div #(
  parameter int NW = 74,
  parameter int DW = 50,
  parameter int QW = 24
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [NW-1:0]  num,
  input  wire logic [DW-1:0]  den,
  output logic                done,
  output logic      [QW-1:0]  quot
);

  localparam int CNT_W = $clog2(QW + 1);

  logic [NW-1:0]    r;
  logic [NW-1:0]    dsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= CNT_W'(QW);
        r    <= num;
        dsh  <= NW'({den, {(QW-1){1'b0}}});
        quot <= '0;
      end else if (busy) begin
        if (r >= dsh) begin
          r    <= r - dsh;
          quot <= {quot[QW-2:0], 1'b1};
        end else begin
          quot <= {quot[QW-2:0], 1'b0};
        end
        dsh  <= {1'b0, dsh[NW-1:1]};
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/polyline_arc_length_interpolator.sv
// Top level of the polyline arc-length interpolator: sequencer and datapath.
// Depends on plal_pkg, plal_ram, plal_sqrt, plal_mul, plal_div and the macro header.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  cmd, vertex_index, in_x, in_y, in_z,
//                                            path_fraction
//   output   out        out_valid/out_stall  out_x, out_y, out_z, segment_found, status
//   config   in         cfg_write            cfg_data (points_in_use)
//
// One item is in work at a time. A load or a query on a too-short path goes straight from
// acceptance to the final state; a query at fraction zero or one first reads that end point.
// A general query walks the segments once (per segment a vertex read, three squared axis
// differences summed, then the bit-serial square root), then runs the target multiply,
// scans the length table, passes the three read states (S_SEL, S_A_RD, S_B_RD), runs the
// three interpolations (shift-add multiply and restoring divide) and presents the item.
// Reset is synchronous and clears control state only; no memory clearing pass is run.
// A result waiting on a stalled output holds the sequencer in its final state.
`default_nettype none

module polyline_arc_length_interpolator #(
  parameter int MAX_POINTS  = 16,
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          cmd,
  input  wire logic [3:0]                    vertex_index,
  input  wire logic signed [COORD_WIDTH-1:0] in_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_z,
  input  wire logic [16:0]                   path_fraction,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0]      out_x,
  output logic signed [COORD_WIDTH-1:0]      out_y,
  output logic signed [COORD_WIDTH-1:0]      out_z,
  output logic [3:0]                         segment_found,
  output logic [1:0]                         status,
  input  wire logic                          cfg_write,
  input  wire logic [4:0]                    cfg_data
);

`include "polyline_arc_length_interpolator_macros.svh"

  localparam int CW   = COORD_WIDTH;
  localparam int IW   = $clog2(MAX_POINTS);
  localparam int FB   = plal_pkg::FRAC_BITS;
  localparam int LW   = CW + 9;            // segment length, 8 fraction bits
  localparam int SW   = 2 * CW + 2;        // sum of three squares
  localparam int TW   = LW + IW;           // total and running length
  localparam int GW   = TW + FB;           // target distance
  localparam int DNW  = LW + FB;           // segment length scaled by 2^16
  localparam int MBW  = (CW > FB) ? CW : FB;
  localparam int MPW  = DNW + MBW;
  localparam int NW   = CW + DNW + 1;      // interpolation numerator
  localparam int VW   = 3 * CW;

  plal_pkg::state_t state, state_next;

  logic [4:0]      points_in_use;
  logic [1:0]      axis;
  logic [IW-1:0]   k;
  logic [IW-1:0]   nm1;
  logic [IW-1:0]   nm2;
  logic [FB-1:0]   t_reg;
  logic [VW-1:0]   prev;
  logic [VW-1:0]   cur;
  logic [SW-1:0]   sum;
  logic [2*CW-1:0] sq;
  logic [TW-1:0]   total;
  logic [TW-1:0]   cum;
  logic [GW-1:0]   target;
  logic [IW-1:0]   sel;
  logic [LW-1:0]   len;
  logic [DNW-1:0]  remv;
  logic [CW-1:0]   res_x, res_y, res_z;
  logic [3:0]      res_seg;
  logic [1:0]      res_status;

  // Memory and unit strobes from the sequencer.
  logic            v_re;
  logic [IW-1:0]   v_raddr;
  logic [VW-1:0]   v_rdata;
  logic            v_we;
  logic [IW-1:0]   v_waddr;
  logic            l_re;
  logic [IW-1:0]   l_raddr;
  logic [LW-1:0]   l_rdata;
  logic            l_we;
  logic            sqrt_start, sqrt_done;
  logic [LW-1:0]   sqrt_root;
  logic            mul_start, mul_done;
  logic [DNW-1:0]  mul_a;
  logic [MBW-1:0]  mul_b;
  logic [MPW-1:0]  mul_prod;
  logic            div_start, div_done;
  logic [CW-1:0]   div_quot;

  logic            in_acc, out_acc, out_free;
  logic [31:0]     vi_w, pu_w, n_w, nm1_w, nm2_w;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != plal_pkg::S_IDLE);

  // Effective point count saturates at the store depth.
  assign pu_w  = 32'(points_in_use);
  assign n_w   = (pu_w > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : pu_w;
  assign nm1_w = n_w - 32'd1;
  assign nm2_w = n_w - 32'd2;
  assign vi_w  = 32'(vertex_index);

  assign v_we    = in_acc && (cmd == plal_pkg::CMD_LOAD) && (vi_w < 32'(MAX_POINTS));
  assign v_waddr = vi_w[IW-1:0];

  // Per-axis difference of the current segment end points (cur minus prev).
  logic [CW-1:0] a_ax, b_ax;
  logic [CW:0]   dlt, dmag;
  logic [CW-1:0] dabs;
  logic          dneg;

  always_comb begin
    case (axis)
      2'd0: begin
        a_ax = prev[CW-1:0];
        b_ax = cur[CW-1:0];
      end
      2'd1: begin
        a_ax = prev[2*CW-1:CW];
        b_ax = cur[2*CW-1:CW];
      end
      2'd2: begin
        a_ax = prev[3*CW-1:2*CW];
        b_ax = cur[3*CW-1:2*CW];
      end
      default: begin
        a_ax = '0;
        b_ax = '0;
      end
    endcase
  end

  assign dlt  = {b_ax[CW-1], b_ax} - {a_ax[CW-1], a_ax};
  assign dneg = dlt[CW];
  assign dmag = dneg ? (~dlt + 1'b1) : dlt;
  assign dabs = dmag[CW-1:0];

  logic [2*CW-1:0] sq_c;
  logic [SW-1:0]   sum_c;
  assign sq_c  = {{CW{1'b0}}, dabs} * {{CW{1'b0}}, dabs};
  assign sum_c = sum + SW'(sq);

  logic [TW-1:0]  next_c;
  logic [DNW-1:0] den;
  logic [GW-1:0]  rem_c;
  logic [NW-1:0]  num_c;
  logic [CW:0]    vsum;

  assign next_c = cum + TW'(l_rdata);
  assign den    = {len, {FB{1'b0}}};
  assign rem_c  = target - {cum, {FB{1'b0}}};
  assign num_c  = {mul_prod[CW+DNW-1:0], 1'b0} + NW'(den);
  assign vsum   = dneg ? ({a_ax[CW-1], a_ax} - {1'b0, div_quot})
                       : ({a_ax[CW-1], a_ax} + {1'b0, div_quot});

  // Sequencer: next state and strobes.
  always_comb begin
    state_next = state;
    v_re       = 1'b0;
    v_raddr    = '0;
    l_re       = 1'b0;
    l_raddr    = '0;
    l_we       = 1'b0;
    sqrt_start = 1'b0;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    case (state)
      plal_pkg::S_IDLE: begin
        if (in_acc) begin
          if (cmd == plal_pkg::CMD_LOAD || n_w < 32'd2) begin
            state_next = plal_pkg::S_DONE;
          end else if (path_fraction == 17'd0) begin
            v_re       = 1'b1;
            v_raddr    = '0;
            state_next = plal_pkg::S_PT_RD;
          end else if (path_fraction >= plal_pkg::FRAC_ONE) begin
            v_re       = 1'b1;
            v_raddr    = nm1_w[IW-1:0];
            state_next = plal_pkg::S_PT_RD;
          end else begin
            v_re       = 1'b1;
            v_raddr    = '0;
            state_next = plal_pkg::S_L_RD;
          end
        end
      end
      plal_pkg::S_PT_RD: begin
        state_next = plal_pkg::S_DONE;
      end
      plal_pkg::S_L_RD: begin
        if (k == '0) begin
          v_re       = 1'b1;
          v_raddr    = IW'(1);
        end else begin
          state_next = plal_pkg::S_SQ;
        end
      end
      plal_pkg::S_SQ: begin
        state_next = plal_pkg::S_ACC;
      end
      plal_pkg::S_ACC: begin
        if (axis == 2'd2) begin
          sqrt_start = 1'b1;
          state_next = plal_pkg::S_SQRT;
        end else begin
          state_next = plal_pkg::S_SQ;
        end
      end
      plal_pkg::S_SQRT: begin
        if (sqrt_done) begin
          l_we = 1'b1;
          if (k == nm1) begin
            state_next = plal_pkg::S_TMUL_GO;
          end else begin
            v_re       = 1'b1;
            v_raddr    = k + 1'b1;
            state_next = plal_pkg::S_L_RD;
          end
        end
      end
      plal_pkg::S_TMUL_GO: begin
        mul_start  = 1'b1;
        mul_a      = DNW'(total);
        mul_b      = MBW'(t_reg);
        state_next = plal_pkg::S_TMUL;
      end
      plal_pkg::S_TMUL: begin
        if (mul_done) begin
          l_re       = 1'b1;
          l_raddr    = '0;
          state_next = plal_pkg::S_SCAN;
        end
      end
      plal_pkg::S_SCAN: begin
        if (target <= {next_c, {FB{1'b0}}} || k == nm2) begin
          state_next = plal_pkg::S_SEL;
        end else begin
          l_re       = 1'b1;
          l_raddr    = k + 1'b1;
        end
      end
      plal_pkg::S_SEL: begin
        v_re    = 1'b1;
        v_raddr = sel;
        if (len == '0) begin
          state_next = plal_pkg::S_PT_RD;
        end else begin
          state_next = plal_pkg::S_A_RD;
        end
      end
      plal_pkg::S_A_RD: begin
        v_re       = 1'b1;
        v_raddr    = sel + 1'b1;
        state_next = plal_pkg::S_B_RD;
      end
      plal_pkg::S_B_RD: begin
        state_next = plal_pkg::S_IMUL_GO;
      end
      plal_pkg::S_IMUL_GO: begin
        mul_start  = 1'b1;
        mul_a      = remv;
        mul_b      = MBW'(dabs);
        state_next = plal_pkg::S_IMUL;
      end
      plal_pkg::S_IMUL: begin
        if (mul_done) begin
          div_start  = 1'b1;
          state_next = plal_pkg::S_IDIV;
        end
      end
      plal_pkg::S_IDIV: begin
        if (div_done) begin
          if (axis == 2'd2) begin
            state_next = plal_pkg::S_DONE;
          end else begin
            state_next = plal_pkg::S_IMUL_GO;
          end
        end
      end
      plal_pkg::S_DONE: begin
        if (out_free) begin
          state_next = plal_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = plal_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plal_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        points_in_use <= cfg_data;
      end
      if (state == plal_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      plal_pkg::S_IDLE: begin
        if (in_acc) begin
          res_x      <= '0;
          res_y      <= '0;
          res_z      <= '0;
          t_reg      <= path_fraction[FB-1:0];
          nm1        <= nm1_w[IW-1:0];
          nm2        <= nm2_w[IW-1:0];
          k          <= '0;
          total      <= '0;
          if (cmd == plal_pkg::CMD_LOAD) begin
            res_status <= plal_pkg::STATUS_LOAD;
          end else if (n_w < 32'd2) begin
            res_status <= plal_pkg::STATUS_FEW;
          end else begin
            res_status <= plal_pkg::STATUS_OK;
          end
          // A query at the far end names the last segment.
          if (cmd == plal_pkg::CMD_QUERY && n_w >= 32'd2 &&
              path_fraction >= plal_pkg::FRAC_ONE) begin
            res_seg <= nm2_w[3:0];
          end else begin
            res_seg <= '0;
          end
        end
      end
      plal_pkg::S_PT_RD: begin
        res_x <= v_rdata[CW-1:0];
        res_y <= v_rdata[2*CW-1:CW];
        res_z <= v_rdata[3*CW-1:2*CW];
      end
      plal_pkg::S_L_RD: begin
        prev <= cur;
        cur  <= v_rdata;
        axis <= 2'd0;
        sum  <= '0;
        if (k == '0) begin
          k <= IW'(1);
        end
      end
      plal_pkg::S_SQ: begin
        sq <= sq_c;
      end
      plal_pkg::S_ACC: begin
        sum  <= sum_c;
        axis <= axis + 2'd1;
      end
      plal_pkg::S_SQRT: begin
        if (sqrt_done) begin
          total <= total + TW'(sqrt_root);
          if (k != nm1) begin
            k <= k + 1'b1;
          end
        end
      end
      plal_pkg::S_TMUL: begin
        if (mul_done) begin
          target <= mul_prod[GW-1:0];
          cum    <= '0;
          k      <= '0;
        end
      end
      plal_pkg::S_SCAN: begin
        if (target <= {next_c, {FB{1'b0}}} || k == nm2) begin
          sel <= k;
          len <= l_rdata;
        end else begin
          cum <= next_c;
          k   <= k + 1'b1;
        end
      end
      plal_pkg::S_SEL: begin
        res_seg <= 4'(32'(sel));
        remv    <= (rem_c > GW'(den)) ? den : rem_c[DNW-1:0];
      end
      plal_pkg::S_A_RD: begin
        prev <= v_rdata;
      end
      plal_pkg::S_B_RD: begin
        cur  <= v_rdata;
        axis <= 2'd0;
      end
      plal_pkg::S_IDIV: begin
        if (div_done) begin
          case (axis)
            2'd0:    res_x <= vsum[CW-1:0];
            2'd1:    res_y <= vsum[CW-1:0];
            default: res_z <= vsum[CW-1:0];
          endcase
          axis <= axis + 2'd1;
        end
      end
      plal_pkg::S_DONE: begin
        if (out_free) begin
          out_x         <= res_x;
          out_y         <= res_y;
          out_z         <= res_z;
          segment_found <= res_seg;
          status        <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

  // Vertex store: x in the low field, then y, then z.
  plal_ram #(
    .DEPTH(MAX_POINTS),
    .WIDTH(VW)
  ) u_vstore (
    .clk  (clk),
    .we   (v_we),
    .waddr(v_waddr),
    .wdata({in_z, in_y, in_x}),
    .re   (v_re),
    .raddr(v_raddr),
    .rdata(v_rdata)
  );

  // Segment length table, written during the length pass at entry k-1.
  plal_ram #(
    .DEPTH(MAX_POINTS),
    .WIDTH(LW)
  ) u_lens (
    .clk  (clk),
    .we   (l_we),
    .waddr(k - 1'b1),
    .wdata(sqrt_root),
    .re   (l_re),
    .raddr(l_raddr),
    .rdata(l_rdata)
  );

  plal_sqrt #(
    .ROOT_W(LW)
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sqrt_start),
    .radicand({sum_c, {FB{1'b0}}}),
    .done    (sqrt_done),
    .root    (sqrt_root)
  );

  plal_mul #(
    .AW(DNW),
    .BW(MBW)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  plal_div #(
    .NW(NW),
    .DW(DNW + 1),
    .QW(CW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num_c),
    .den  ({den, 1'b0}),
    .done (div_done),
    .quot (div_quot)
  );

  // A finished root must land while the sequencer is waiting for it.
  `PLAL_ASSERT_IMP(a_sqrt_in_state, sqrt_done, state == plal_pkg::S_SQRT)
  // A load acknowledgement carries no point and no segment.
  `PLAL_ASSERT_IMP(a_load_clean, out_valid && status == plal_pkg::STATUS_LOAD,
    out_x == '0 && out_y == '0 && out_z == '0 && segment_found == '0)
  // A too-short path result carries no point and no segment.
  `PLAL_ASSERT_IMP(a_few_clean, out_valid && status == plal_pkg::STATUS_FEW,
    out_x == '0 && out_y == '0 && out_z == '0 && segment_found == '0)

endmodule

`default_nettype wire
